// ===== rtl/rhht_pkg.sv =====
// ============================================================================
// rhht_pkg - Robin Hood hash table shared definitions
// Table geometry, item layouts, operation and status codes, FSM states.
// ============================================================================
package rhht_pkg;

   // Table geometry (SLOTS must be a power of two)
   localparam int SLOTS      = 256;
   localparam int SLOT_BITS  = $clog2(SLOTS);
   localparam int COUNT_BITS = SLOT_BITS + 1;
   localparam int HASH_BITS  = 32;
   localparam int VALUE_BITS = 32;
   localparam int LIMIT_BITS = 9;
   localparam int CMP_BITS   = ((COUNT_BITS > LIMIT_BITS) ? COUNT_BITS : LIMIT_BITS) + 1;

   localparam logic [LIMIT_BITS-1:0] LOAD_LIMIT_RESET = LIMIT_BITS'(192);

   // Operation codes
   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_LOOKUP = 2'd1;
   localparam logic [1:0] OP_DELETE = 2'd2;

   // Status codes
   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_MISS = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;

   typedef struct packed {
      logic [1:0]            op;
      logic [HASH_BITS-1:0]  key_hash;
      logic [VALUE_BITS-1:0] data_value;
   } req_type;

   typedef struct packed {
      logic [1:0]            status;
      logic [VALUE_BITS-1:0] found_value;
      logic [COUNT_BITS-1:0] entry_total;
   } rsp_type;

   typedef struct packed {
      logic [HASH_BITS-1:0]  hash;
      logic [VALUE_BITS-1:0] value;
      logic [SLOT_BITS-1:0]  distance;
   } entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INS_EVAL,
      ST_FIND_EVAL,
      ST_SHIFT_EVAL,
      ST_DONE
   } state_type;

endpackage

// ===== rtl/robin_hood_hash_table.sv =====
// ============================================================================
// robin_hood_hash_table - open-addressed Robin Hood hash table
// Insert with displacement, lookup, and delete with backward shift over a
// slot memory with a registered read port.
// ============================================================================
//
//   channel | ports                               | direction | payload
//   --------+-------------------------------------+-----------+------------------
//   request | req_valid, req_stall, req_data      | in        | op, hash, value
//   result  | rsp_valid, rsp_stall, rsp_data      | out       | status, value, total
//   config  | csr_write_enable, csr_write_data    | in        | load limit
//
// One item at a time. Accept issues the home slot read; each probed or shifted
// slot then gets its own evaluation step, and the final state loads the result
// register. A full insert or an unused code goes from accept straight to the
// final state. Reset empties the table at once (slot valid bits live in flops).
// A stalled result holds while the next item runs; the block waits in the final
// state only if that item finishes first.
//
module robin_hood_hash_table (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  rhht_pkg::req_type                    req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output rhht_pkg::rsp_type                    rsp_data,
   input  logic                                 csr_write_enable,
   input  logic [rhht_pkg::LIMIT_BITS-1:0]      csr_write_data
);

   localparam int SB = rhht_pkg::SLOT_BITS;
   localparam int CB = rhht_pkg::COUNT_BITS;

   // Slot payload memory: one write and one registered read per cycle
   rhht_pkg::entry_type slot_mem [rhht_pkg::SLOTS];
   rhht_pkg::entry_type rd_entry_ff;
   rhht_pkg::entry_type mem_wdata;
   logic [SB-1:0]       mem_waddr;
   logic [SB-1:0]       mem_raddr;
   logic                mem_we;

   // Control and working registers
   rhht_pkg::state_type              state_ff, state_in;
   logic [rhht_pkg::SLOTS-1:0]       used_ff, used_in;
   logic [CB-1:0]                    count_ff, count_in;
   logic [rhht_pkg::LIMIT_BITS-1:0]  limit_ff, limit_in;
   logic [SB-1:0]                    pos_ff, pos_in;
   logic [CB-1:0]                    probe_ff, probe_in;
   logic [1:0]                       op_ff, op_in;
   logic [rhht_pkg::HASH_BITS-1:0]   carry_hash_ff, carry_hash_in;
   logic [rhht_pkg::VALUE_BITS-1:0]  carry_value_ff, carry_value_in;
   logic [1:0]                       res_status_ff, res_status_in;
   logic [rhht_pkg::VALUE_BITS-1:0]  res_value_ff, res_value_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   rhht_pkg::rsp_type                rsp_data_ff, rsp_data_in;

   logic          req_accept;
   logic          rsp_free;
   logic          rd_used;
   logic          is_full;
   logic [SB-1:0] pos_next;
   logic [SB-1:0] pos_prev;
   logic [CB-1:0] rd_dist_ext;

   assign req_stall  = (state_ff != rhht_pkg::ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   assign rd_used     = used_ff[pos_ff];
   assign pos_next    = pos_ff + SB'(1);
   assign pos_prev    = pos_ff - SB'(1);
   assign rd_dist_ext = {1'b0, rd_entry_ff.distance};

   // Reject when count + 1 reaches the limit, or the table is physically full
   assign is_full = (rhht_pkg::CMP_BITS'(count_ff) + rhht_pkg::CMP_BITS'(1)
                     >= rhht_pkg::CMP_BITS'(limit_ff))
                 || (count_ff >= CB'(rhht_pkg::SLOTS));

   // Memory: write and registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem[mem_waddr] <= mem_wdata;
      end
      rd_entry_ff <= slot_mem[mem_raddr];
   end

   // State and registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rhht_pkg::ST_IDLE;
         used_ff      <= '0;
         count_ff     <= '0;
         limit_ff     <= rhht_pkg::LOAD_LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         count_ff     <= count_in;
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pos_ff         <= pos_in;
      probe_ff       <= probe_in;
      op_ff          <= op_in;
      carry_hash_ff  <= carry_hash_in;
      carry_value_ff <= carry_value_in;
      res_status_ff  <= res_status_in;
      res_value_ff   <= res_value_in;
      rsp_data_ff    <= rsp_data_in;
   end

   // Next state and datapath
   always_comb begin
      state_in       = state_ff;
      used_in        = used_ff;
      count_in       = count_ff;
      limit_in       = csr_write_enable ? csr_write_data : limit_ff;
      pos_in         = pos_ff;
      probe_in       = probe_ff;
      op_in          = op_ff;
      carry_hash_in  = carry_hash_ff;
      carry_value_in = carry_value_ff;
      res_status_in  = res_status_ff;
      res_value_in   = res_value_ff;
      // drop the result once the consumer takes it
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_data_in    = rsp_data_ff;
      mem_we         = 1'b0;
      mem_waddr      = pos_ff;
      mem_wdata      = '{hash: carry_hash_ff, value: carry_value_ff,
                         distance: probe_ff[SB-1:0]};
      // by default prefetch the next slot of the run
      mem_raddr      = pos_next;

      case (state_ff)
         rhht_pkg::ST_IDLE: begin
            // issue the home slot read as the item arrives
            mem_raddr = req_data.key_hash[SB-1:0];
            if (req_accept) begin
               pos_in         = req_data.key_hash[SB-1:0];
               probe_in       = '0;
               op_in          = req_data.op;
               carry_hash_in  = req_data.key_hash;
               carry_value_in = req_data.data_value;
               res_value_in   = '0;
               case (req_data.op)
                  rhht_pkg::OP_INSERT: begin
                     if (is_full) begin
                        res_status_in = rhht_pkg::ST_FULL;
                        state_in      = rhht_pkg::ST_DONE;
                     end else begin
                        state_in = rhht_pkg::ST_INS_EVAL;
                     end
                  end
                  rhht_pkg::OP_LOOKUP,
                  rhht_pkg::OP_DELETE: begin
                     state_in = rhht_pkg::ST_FIND_EVAL;
                  end
                  default: begin
                     res_status_in = rhht_pkg::ST_MISS;
                     state_in      = rhht_pkg::ST_DONE;
                  end
               endcase
            end
         end

         rhht_pkg::ST_INS_EVAL: begin
            if (!rd_used) begin
               // empty slot takes the carried entry
               mem_we           = 1'b1;
               used_in[pos_ff]  = 1'b1;
               count_in         = count_ff + CB'(1);
               res_status_in    = rhht_pkg::ST_OK;
               res_value_in     = '0;
               state_in         = rhht_pkg::ST_DONE;
            end else begin
               if (probe_ff > rd_dist_ext) begin
                  // richer resident: swap and carry it on
                  mem_we         = 1'b1;
                  carry_hash_in  = rd_entry_ff.hash;
                  carry_value_in = rd_entry_ff.value;
                  probe_in       = rd_dist_ext + CB'(1);
               end else begin
                  probe_in = probe_ff + CB'(1);
               end
               pos_in = pos_next;
            end
         end

         rhht_pkg::ST_FIND_EVAL: begin
            if (!rd_used || (probe_ff > rd_dist_ext)) begin
               res_status_in = rhht_pkg::ST_MISS;
               res_value_in  = '0;
               state_in      = rhht_pkg::ST_DONE;
            end else if (rd_entry_ff.hash == carry_hash_ff) begin
               res_status_in = rhht_pkg::ST_OK;
               res_value_in  = rd_entry_ff.value;
               if (op_ff == rhht_pkg::OP_DELETE) begin
                  // open the hole and start the backward shift
                  used_in[pos_ff] = 1'b0;
                  if (count_ff != '0) begin
                     count_in = count_ff - CB'(1);
                  end
                  probe_in = '0;
                  pos_in   = pos_next;
                  state_in = rhht_pkg::ST_SHIFT_EVAL;
               end else begin
                  state_in = rhht_pkg::ST_DONE;
               end
            end else if (probe_ff == CB'(rhht_pkg::SLOTS - 1)) begin
               res_status_in = rhht_pkg::ST_MISS;
               res_value_in  = '0;
               state_in      = rhht_pkg::ST_DONE;
            end else begin
               probe_in = probe_ff + CB'(1);
               pos_in   = pos_next;
            end
         end

         rhht_pkg::ST_SHIFT_EVAL: begin
            if (!rd_used || (rd_entry_ff.distance == '0)) begin
               state_in = rhht_pkg::ST_DONE;
            end else begin
               // move the resident back one slot
               mem_we            = 1'b1;
               mem_waddr         = pos_prev;
               mem_wdata         = '{hash: rd_entry_ff.hash, value: rd_entry_ff.value,
                                     distance: rd_entry_ff.distance - SB'(1)};
               used_in[pos_prev] = 1'b1;
               used_in[pos_ff]   = 1'b0;
               if (probe_ff == CB'(rhht_pkg::SLOTS - 2)) begin
                  state_in = rhht_pkg::ST_DONE;
               end else begin
                  probe_in = probe_ff + CB'(1);
                  pos_in   = pos_next;
               end
            end
         end

         rhht_pkg::ST_DONE: begin
            // hold until the result register is free
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{status: res_status_ff, found_value: res_value_ff,
                                entry_total: count_ff};
               state_in     = rhht_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = rhht_pkg::ST_IDLE;
         end
      endcase
   end

`ifndef SYNTHESIS
   // stored count always matches the number of occupied slots
   a_count_matches_used: assert property (@(posedge clock) disable iff (reset)
      $countones(used_ff) == 32'(count_ff))
      else $error("entry count disagrees with occupied slots");

   // a write never targets the slot being read in the same cycle
   a_no_rw_collision: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (mem_waddr != mem_raddr))
      else $error("memory read and write hit the same slot");

   // a finished item lands in the result register once it is free
   a_done_loads_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rhht_pkg::ST_DONE) && rsp_free |=> rsp_valid_ff)
      else $error("completed item did not reach the result register");

   // count never exceeds the table size
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CB'(rhht_pkg::SLOTS))
      else $error("entry count beyond table size");
`endif

endmodule

// ===== tb/sv/robin_hood_hash_table_tb.sv =====
// ============================================================================
// robin_hood_hash_table_tb - self-checking bench for the Robin Hood hash table
// Sends insert, lookup and delete items through the valid/stall channels and
// compares every result item, field by field, with a shadow table kept in a
// small scoreboard. Covers load limit settings, probe runs that wrap past the
// last slot, a physically full table and long backward shifts.
// ============================================================================
module robin_hood_hash_table_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int         CLOCK_PERIOD = 10;
   localparam logic [1:0] OP_UNUSED    = 2'd3;

   // Shadow of the slot memory; predicts one result item per accepted item.
   class hash_table_shadow;
      bit                              used     [rhht_pkg::SLOTS];
      logic [rhht_pkg::HASH_BITS-1:0]  key      [rhht_pkg::SLOTS];
      logic [rhht_pkg::VALUE_BITS-1:0] val      [rhht_pkg::SLOTS];
      int unsigned                     distance [rhht_pkg::SLOTS];
      int unsigned                     entries;
      int unsigned                     limit;
      rhht_pkg::rsp_type               due_results [$];
      int unsigned                     mismatches;

      function new();
         foreach (used[i]) used[i] = 1'b0;
         entries    = 0;
         limit      = 32'(rhht_pkg::LOAD_LIMIT_RESET);
         mismatches = 0;
      endfunction

      function void set_limit(logic [rhht_pkg::LIMIT_BITS-1:0] v);
         limit = 32'(v);
      endfunction

      // Slot holding the hash, or -1 once an empty slot or a richer resident stops the walk.
      function int locate(logic [rhht_pkg::HASH_BITS-1:0] h);
         int unsigned pos;
         pos = 32'(h[rhht_pkg::SLOT_BITS-1:0]);
         for (int unsigned probe = 0; probe < rhht_pkg::SLOTS; probe++) begin
            if (!used[pos] || probe > distance[pos]) return -1;
            if (key[pos] == h) return pos;
            pos = (pos + 1) % rhht_pkg::SLOTS;
         end
         return -1;
      endfunction

      // Walk from home, trading places with any resident closer to its home.
      function void place(logic [rhht_pkg::HASH_BITS-1:0] h,
                          logic [rhht_pkg::VALUE_BITS-1:0] v);
         int unsigned                     pos;
         int unsigned                     d;
         int unsigned                     td;
         logic [rhht_pkg::HASH_BITS-1:0]  th;
         logic [rhht_pkg::VALUE_BITS-1:0] tv;
         pos = 32'(h[rhht_pkg::SLOT_BITS-1:0]);
         d   = 0;
         for (int n = 0; n < rhht_pkg::SLOTS; n++) begin
            if (!used[pos]) begin
               used[pos]     = 1'b1;
               key[pos]      = h;
               val[pos]      = v;
               distance[pos] = d;
               return;
            end
            if (d > distance[pos]) begin
               th = key[pos];
               tv = val[pos];
               td = distance[pos];
               key[pos]      = h;
               val[pos]      = v;
               distance[pos] = d;
               h = th;
               v = tv;
               d = td;
            end
            pos = (pos + 1) % rhht_pkg::SLOTS;
            d++;
         end
      endfunction

      // Pull the run behind the hole back by one slot, at most SLOTS-1 moves.
      function void close_gap(int unsigned hole);
         int unsigned cur;
         int unsigned prv;
         cur = hole;
         for (int n = 0; n + 1 < rhht_pkg::SLOTS; n++) begin
            cur = (cur + 1) % rhht_pkg::SLOTS;
            if (!used[cur] || distance[cur] == 0) return;
            prv = (cur + rhht_pkg::SLOTS - 1) % rhht_pkg::SLOTS;
            used[prv]     = 1'b1;
            key[prv]      = key[cur];
            val[prv]      = val[cur];
            distance[prv] = distance[cur] - 1;
            used[cur]     = 1'b0;
         end
      endfunction

      function void note_request(rhht_pkg::req_type r);
         rhht_pkg::rsp_type want;
         int                at;
         want.status      = rhht_pkg::ST_MISS;
         want.found_value = '0;
         case (r.op)
            rhht_pkg::OP_INSERT: begin
               if (entries + 1 >= limit || entries >= rhht_pkg::SLOTS) begin
                  want.status = rhht_pkg::ST_FULL;
               end else begin
                  place(r.key_hash, r.data_value);
                  entries++;
                  want.status = rhht_pkg::ST_OK;
               end
            end
            rhht_pkg::OP_LOOKUP: begin
               at = locate(r.key_hash);
               if (at >= 0) begin
                  want.status      = rhht_pkg::ST_OK;
                  want.found_value = val[at];
               end
            end
            rhht_pkg::OP_DELETE: begin
               at = locate(r.key_hash);
               if (at >= 0) begin
                  want.status      = rhht_pkg::ST_OK;
                  want.found_value = val[at];
                  used[at]         = 1'b0;
                  close_gap(at);
                  if (entries > 0) entries--;
               end
            end
            default: ;
         endcase
         want.entry_total = rhht_pkg::COUNT_BITS'(entries);
         due_results.push_back(want);
      endfunction

      function void report(string field, logic [rhht_pkg::VALUE_BITS-1:0] want,
                           logic [rhht_pkg::VALUE_BITS-1:0] got);
         mismatches++;
         $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                  $time, field, want, got);
      endfunction

      function void check_result(rhht_pkg::rsp_type got);
         rhht_pkg::rsp_type want;
         if (due_results.size() == 0) begin
            mismatches++;
            $display({"%0t ns: result item with none expected, ",
                      "actual status %0d value 0x%0h total %0d"},
                     $time, got.status, got.found_value, got.entry_total);
            return;
         end
         want = due_results.pop_front();
         if (got.status !== want.status)
            report("status", rhht_pkg::VALUE_BITS'(want.status),
                   rhht_pkg::VALUE_BITS'(got.status));
         if (got.found_value !== want.found_value)
            report("found_value", want.found_value, got.found_value);
         if (got.entry_total !== want.entry_total)
            report("entry_total", rhht_pkg::VALUE_BITS'(want.entry_total),
                   rhht_pkg::VALUE_BITS'(got.entry_total));
      endfunction

      // Hash of some stored entry, searched from a random slot.
      function logic [rhht_pkg::HASH_BITS-1:0] any_stored();
         int unsigned s;
         s = $urandom_range(rhht_pkg::SLOTS - 1);
         for (int n = 0; n < rhht_pkg::SLOTS; n++) begin
            if (used[s]) return key[s];
            s = (s + 1) % rhht_pkg::SLOTS;
         end
         return $urandom();
      endfunction
   endclass

   // All block inputs start at known values.
   logic                            clock            = 1'b0;
   logic                            reset            = 1'b1;
   logic                            req_valid        = 1'b0;
   logic                            req_stall;
   rhht_pkg::req_type               req_data         = '0;
   logic                            rsp_valid;
   logic                            rsp_stall        = 1'b0;
   rhht_pkg::rsp_type               rsp_data;
   logic                            csr_write_enable = 1'b0;
   logic [rhht_pkg::LIMIT_BITS-1:0] csr_write_data   = '0;

   // Idle chances in percent per cycle for the sender and the receiver.
   int unsigned send_gap_pct = 0;
   int unsigned stall_pct    = 0;

   hash_table_shadow book = new();

   robin_hood_hash_table u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // Receiver: stall at random, one decision per cycle on the falling edge.
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // Check each result item taken at a rising edge against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) book.check_result(rsp_data);
   end

   // Offer one item, hold it until taken, and note it with the scoreboard.
   // Leave valid high on return so valid need not drop between items.
   task automatic send_req(input logic [1:0] op,
                           input logic [rhht_pkg::HASH_BITS-1:0] h,
                           input logic [rhht_pkg::VALUE_BITS-1:0] v);
      rhht_pkg::req_type item;
      int unsigned       gap;
      item.op         = op;
      item.key_hash   = h;
      item.data_value = v;
      gap = 0;
      while ($urandom_range(99) < send_gap_pct) gap++;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      book.note_request(item);
      @(negedge clock);
   endtask

   // Drop valid and hold off until every predicted result item has come back.
   task automatic drain();
      req_valid <= 1'b0;
      do @(negedge clock); while (book.due_results.size() != 0);
   endtask

   // Write the load limit only while the table is idle.
   task automatic write_limit(input logic [rhht_pkg::LIMIT_BITS-1:0] v);
      drain();
      csr_write_enable <= 1'b1;
      csr_write_data   <= v;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      book.set_limit(v);
   endtask

   // Keys crowd a window of homes across the last slot and share a few
   // upper patterns, so runs grow long, wrap, and repeat hashes show up.
   function automatic logic [rhht_pkg::HASH_BITS-1:0] random_key();
      logic [rhht_pkg::HASH_BITS-1:0] k;
      k = $urandom();
      if ($urandom_range(1) != 0)
         k[rhht_pkg::HASH_BITS-1:rhht_pkg::SLOT_BITS] =
            (rhht_pkg::HASH_BITS - rhht_pkg::SLOT_BITS)'($urandom_range(7));
      if ($urandom_range(3) != 0)
         k[rhht_pkg::SLOT_BITS-1:0] =
            rhht_pkg::SLOT_BITS'(rhht_pkg::SLOTS - 8 + $urandom_range(11));
      return k;
   endfunction

   // Mixed traffic; lookups and deletes mostly aim at stored keys.
   task automatic random_run(input int unsigned count);
      int unsigned                    pick;
      logic [1:0]                     op;
      logic [rhht_pkg::HASH_BITS-1:0] h;
      repeat (count) begin
         pick = $urandom_range(99);
         if (pick < 45)      op = rhht_pkg::OP_INSERT;
         else if (pick < 75) op = rhht_pkg::OP_LOOKUP;
         else if (pick < 96) op = rhht_pkg::OP_DELETE;
         else                op = OP_UNUSED;
         h = random_key();
         if (op != rhht_pkg::OP_INSERT && book.entries != 0 && $urandom_range(9) < 6)
            h = book.any_stored();
         send_req(op, h, $urandom());
         // Now and then let the table run dry before going on.
         if ($urandom_range(63) == 0) drain();
      end
   endtask

   initial begin
      int unsigned                    home;
      logic [rhht_pkg::HASH_BITS-1:0] k;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Sender idles a little, receiver stalls a lot.
      send_gap_pct = 21;
      stall_pct    = 88;

      // Empty table, unused code, field extremes.
      send_req(rhht_pkg::OP_LOOKUP, '0, '0);
      send_req(rhht_pkg::OP_DELETE, '1, '0);
      send_req(OP_UNUSED, '1, '1);
      send_req(rhht_pkg::OP_INSERT, '0, '0);
      send_req(rhht_pkg::OP_INSERT, '1, '1);
      // Home in the last slot collides, displaces the entry in slot 0 and wraps.
      send_req(rhht_pkg::OP_INSERT, 32'h0000_01FF, 32'h5A5A_A5A5);
      // Repeat hash is stored again; lookup reaches the first one.
      send_req(rhht_pkg::OP_INSERT, '1, 32'h1234_5678);
      send_req(rhht_pkg::OP_LOOKUP, '1, '0);
      send_req(rhht_pkg::OP_LOOKUP, '0, '1);
      // Absent key stops at the empty slot behind the run.
      send_req(rhht_pkg::OP_LOOKUP, 32'h0000_0100, '0);
      // Delete in the last slot shifts the run back across slot 0.
      send_req(rhht_pkg::OP_DELETE, '1, '0);
      send_req(rhht_pkg::OP_LOOKUP, '1, '0);
      send_req(rhht_pkg::OP_DELETE, '0, '0);
      send_req(OP_UNUSED, '0, '0);

      // Load limit reached with two stored.
      write_limit(rhht_pkg::LIMIT_BITS'(3));
      send_req(rhht_pkg::OP_INSERT, 32'hA5A5_5A5A, '1);
      send_req(rhht_pkg::OP_DELETE, 32'h0000_01FF, '0);
      send_req(rhht_pkg::OP_INSERT, 32'hA5A5_5A5A, '1);
      send_req(rhht_pkg::OP_INSERT, 32'h5A5A_A5A5, '0);
      // Limit zero and one reject every insert here.
      write_limit('0);
      send_req(rhht_pkg::OP_INSERT, 32'h0F0F_F0F0, 32'hF0F0_0F0F);
      write_limit(rhht_pkg::LIMIT_BITS'(1));
      send_req(rhht_pkg::OP_INSERT, 32'hF0F0_0F0F, 32'h0F0F_F0F0);

      // Largest limit: empty the table, then fill every slot from one home
      // near the top so the run wraps and distances reach SLOTS-1.
      write_limit('1);
      while (book.entries != 0)
         send_req(rhht_pkg::OP_DELETE, book.any_stored(), $urandom());
      home = $urandom_range(rhht_pkg::SLOTS - 16, rhht_pkg::SLOTS - 1);
      while (book.entries < rhht_pkg::SLOTS) begin
         k = $urandom();
         k[rhht_pkg::SLOT_BITS-1:0] = rhht_pkg::SLOT_BITS'(home);
         send_req(rhht_pkg::OP_INSERT, k, $urandom());
      end
      // Table physically full.
      send_req(rhht_pkg::OP_INSERT, $urandom(), $urandom());
      // Absent key walks every slot before giving up.
      k = $urandom();
      k[rhht_pkg::SLOT_BITS-1:0] = rhht_pkg::SLOT_BITS'(home);
      send_req(rhht_pkg::OP_LOOKUP, k, $urandom());
      // Deleting the head of the run shifts the whole table back.
      k = book.key[home];
      send_req(rhht_pkg::OP_DELETE, k, $urandom());
      send_req(rhht_pkg::OP_LOOKUP, k, $urandom());
      // Drain it again in random order with lookups mixed in.
      while (book.entries != 0) begin
         if ($urandom_range(3) == 0)
            send_req(rhht_pkg::OP_LOOKUP, book.any_stored(), $urandom());
         send_req(rhht_pkg::OP_DELETE, book.any_stored(), $urandom());
      end

      // Sender idles a lot, receiver stalls a little.
      send_gap_pct = 88;
      stall_pct    = 21;
      write_limit(rhht_pkg::LIMIT_BITS'(rhht_pkg::SLOTS));
      random_run(100);
      write_limit(rhht_pkg::LIMIT_BITS'($urandom_range(20, 60)));
      random_run(100);

      // No idling on either side.
      send_gap_pct = 0;
      stall_pct    = 0;
      write_limit(rhht_pkg::LIMIT_BITS'($urandom()));
      random_run(50);
      write_limit(rhht_pkg::LOAD_LIMIT_RESET);
      random_run(50);

      // Wait out the last result items, then a few quiet cycles.
      drain();
      repeat (16) @(negedge clock);
      if (book.mismatches == 0 && book.due_results.size() == 0) begin
         $display("robin_hood_hash_table_tb passed");
      end else begin
         $display("robin_hood_hash_table_tb failed");
      end
      $finish;
   end

   // Hard stop well beyond the slowest correct run.
   initial begin
      #20_000_000;
      $display("robin_hood_hash_table_tb failed");
      $finish;
   end

endmodule
